@@ rtl/tfi_pkg.sv @@
package tfi_pkg;

  localparam int NUM_CLASSES = 5;
  localparam int REG_COUNT   = 16;
  localparam int ENTRY_W     = 28;

  // Item kinds carried in the input tuser.
  localparam logic [1:0] OP_FETCH   = 2'd0;
  localparam logic [1:0] OP_ISSUE   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [3:0] OPC_LOAD  = 4'd0;
  localparam logic [3:0] OPC_STORE = 4'd1;
  localparam logic [3:0] OPC_ADD   = 4'd2;
  localparam logic [3:0] OPC_SUB   = 4'd3;
  localparam logic [3:0] OPC_MUL   = 4'd4;
  localparam logic [3:0] OPC_DIV   = 4'd5;
  localparam logic [3:0] OPC_HALT  = 4'd6;

  localparam logic [2:0] CLS_ADD   = 3'd0;
  localparam logic [2:0] CLS_MUL   = 3'd1;
  localparam logic [2:0] CLS_DIV   = 3'd2;
  localparam logic [2:0] CLS_LOAD  = 3'd3;
  localparam logic [2:0] CLS_STORE = 3'd4;
  localparam logic [2:0] CLS_NONE  = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_ADD_COUNT   = 3'd0;
  localparam logic [2:0] REG_MUL_COUNT   = 3'd1;
  localparam logic [2:0] REG_DIV_COUNT   = 3'd2;
  localparam logic [2:0] REG_LOAD_COUNT  = 3'd3;
  localparam logic [2:0] REG_STORE_COUNT = 3'd4;

  typedef logic [NUM_CLASSES-1:0][3:0] tfi_limits_t;

  localparam tfi_limits_t LIMITS_RESET = {4'd3, 4'd3, 4'd2, 4'd2, 4'd3};

  typedef struct packed {
    logic push;
    logic pop;
  } tfi_qctl_t;

  typedef struct packed {
    logic       alloc;
    logic [3:0] dst;
    logic       rel;
    logic [2:0] rel_cls;
    logic [2:0] rel_slot;
  } tfi_sctl_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] cls;
    logic [2:0] slot;
  } tfi_sstat_t;

  // Result item, listed from the top bit down so that the last field lands in bit 0.
  typedef struct packed {
    logic [1:0]  pad;
    logic [4:0]  queue_count;
    logic [11:0] fetch_address;
    logic [11:0] immediate;
    logic [3:0]  src1_reg;
    logic [3:0]  src0_reg;
    logic [3:0]  dst_reg;
    logic [3:0]  opcode;
    logic [2:0]  station_slot;
    logic [2:0]  station_class;
    logic        issued;
    logic        halted;
    logic        fetch_accepted;
  } tfi_result_t;

  function automatic logic [2:0] class_of_opcode(input logic [3:0] opc);
    logic [2:0] cls;
    case (opc) inside
      OPC_ADD, OPC_SUB: cls = CLS_ADD;
      OPC_MUL:          cls = CLS_MUL;
      OPC_DIV:          cls = CLS_DIV;
      OPC_LOAD:         cls = CLS_LOAD;
      OPC_STORE:        cls = CLS_STORE;
      default:          cls = CLS_NONE;
    endcase
    return cls;
  endfunction

endpackage

@@ rtl/tomasulo_fetch_issue_unit.sv @@
// out_tvalid rises when the execute state that follows the taking of the input item registers its result.
// The unit takes no new input item until it has finished the last one; the queue memory's registered head read,
// launched when the item is taken, is consumed in the following execute cycle.
// Reset (synchronous, rst_n low): queue empty, not halted, program counter zero,
// all stations free, no register tags pending, counts back to 3/2/2/3/3.
// The queue memory itself is not cleared; there is no clearing pass.
module tomasulo_fetch_issue_unit
  import tfi_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int MAX_STATIONS = 8,
  parameter int ADDR_BITS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] instr_word, [34:32] release_class, [37:35] release_slot, [39:38] zero
  input  logic [39:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] fetch_accepted, [1] halted, [2] issued, [5:3] station_class,
  // [8:6] station_slot, [12:9] opcode, [16:13] dst_reg, [20:17] src0_reg,
  // [24:21] src1_reg, [36:25] immediate, [48:37] fetch_address,
  // [53:49] queue_count, [55:54] zero
  output logic [55:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state_r, state_nxt;
  logic [1:0]           op_r;
  logic [ENTRY_W-1:0]   entry_r;
  logic [2:0]           rcls_r;
  logic [2:0]           rslot_r;
  logic                 halt_r, halt_nxt;
  logic [ADDR_BITS-1:0] pc_r, pc_nxt;
  tfi_limits_t          limits_r;
  tfi_result_t          res_r, res_nxt;
  logic                 out_valid_r;

  tfi_qctl_t            qctl;
  tfi_sctl_t            sctl;
  tfi_sstat_t           sstat;
  logic [ENTRY_W-1:0]   head_data;
  logic [CW-1:0]        q_fill;
  logic [CW-1:0]        fill_after;
  logic                 q_full;
  logic                 exec;
  logic                 in_take;
  logic                 cfg_wr;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_take   = in_tvalid && in_tready;
  assign exec      = (state_r == ST_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r    <= in_tuser;
      entry_r <= in_tdata[ENTRY_W-1:0];
      rcls_r  <= in_tdata[34:32];
      rslot_r <= in_tdata[37:35];
    end
    if (exec) begin
      res_r <= res_nxt;
    end
  end

  tfi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (qctl),
    .push_data (entry_r),
    .head_data (head_data),
    .fill      (q_fill),
    .full      (q_full)
  );

  tfi_stations #(
    .MAX_STATIONS (MAX_STATIONS)
  ) u_stations (
    .clk         (clk),
    .rst_n       (rst_n),
    .limits      (limits_r),
    .head_opcode (head_data[27:24]),
    .ctl         (sctl),
    .status      (sstat)
  );

  always_comb begin
    qctl.push = exec && (op_r == OP_FETCH) && !halt_r && !q_full;
    qctl.pop  = exec && (op_r == OP_ISSUE) && (q_fill != '0) && sstat.hit;

    sctl.alloc    = qctl.pop;
    sctl.dst      = head_data[23:20];
    sctl.rel      = exec && (op_r == OP_RELEASE);
    sctl.rel_cls  = rcls_r;
    sctl.rel_slot = rslot_r;

    halt_nxt   = halt_r | (qctl.push && (entry_r[27:24] == OPC_HALT));
    pc_nxt     = qctl.push ? pc_r + 1'b1 : pc_r;
    fill_after = q_fill + CW'(qctl.push) - CW'(qctl.pop);

    res_nxt                = '0;
    res_nxt.fetch_accepted = qctl.push;
    res_nxt.halted         = halt_nxt;
    res_nxt.issued         = qctl.pop;
    if (qctl.pop) begin
      res_nxt.station_class = sstat.cls;
      res_nxt.station_slot  = sstat.slot;
      res_nxt.opcode        = head_data[27:24];
      res_nxt.dst_reg       = head_data[23:20];
      res_nxt.src0_reg      = head_data[19:16];
      res_nxt.src1_reg      = head_data[15:12];
      res_nxt.immediate     = head_data[11:0];
    end
    res_nxt.fetch_address = 12'(pc_nxt);
    res_nxt.queue_count   = 5'(fill_after);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      halt_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        halt_r <= halt_nxt;
        pc_r   <= pc_nxt;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r <= LIMITS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_ADD_COUNT:   limits_r[CLS_ADD]   <= cfg_pwdata[3:0];
        REG_MUL_COUNT:   limits_r[CLS_MUL]   <= cfg_pwdata[3:0];
        REG_DIV_COUNT:   limits_r[CLS_DIV]   <= cfg_pwdata[3:0];
        REG_LOAD_COUNT:  limits_r[CLS_LOAD]  <= cfg_pwdata[3:0];
        REG_STORE_COUNT: limits_r[CLS_STORE] <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_ADD_COUNT:   cfg_prdata = {28'd0, limits_r[CLS_ADD]};
      REG_MUL_COUNT:   cfg_prdata = {28'd0, limits_r[CLS_MUL]};
      REG_DIV_COUNT:   cfg_prdata = {28'd0, limits_r[CLS_DIV]};
      REG_LOAD_COUNT:  cfg_prdata = {28'd0, limits_r[CLS_LOAD]};
      REG_STORE_COUNT: cfg_prdata = {28'd0, limits_r[CLS_STORE]};
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

@@ rtl/tfi_queue.sv @@
module tfi_queue
  import tfi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tfi_qctl_t                    ctl,
  input  logic [ENTRY_W-1:0]           push_data,
  output logic [ENTRY_W-1:0]           head_data,
  output logic [$clog2(DEPTH+1)-1:0]   fill,
  output logic                         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0]      head_r;
  logic [AW-1:0]      tail_r;
  logic [CW-1:0]      fill_r;
  logic [ENTRY_W-1:0] rd_r;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
    return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // The head is read every cycle into a register; the execute state that follows the taking of an item uses that value.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= push_data;
    end
    rd_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      if (ctl.push) begin
        tail_r <= wrap_inc(tail_r);
      end
      if (ctl.pop) begin
        head_r <= wrap_inc(head_r);
      end
      fill_r <= fill_r + CW'(ctl.push) - CW'(ctl.pop);
    end
  end

  assign head_data = rd_r;
  assign fill      = fill_r;
  assign full      = (fill_r == CW'(DEPTH));

endmodule

@@ rtl/tfi_stations.sv @@
module tfi_stations
  import tfi_pkg::*;
#(
  parameter int MAX_STATIONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tfi_limits_t limits,
  input  logic [3:0]  head_opcode,
  input  tfi_sctl_t   ctl,
  output tfi_sstat_t  status
);

  localparam int SW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;

  logic [NUM_CLASSES-1:0][MAX_STATIONS-1:0] busy_r;
  logic [5:0]            tag_mem [REG_COUNT];
  logic [REG_COUNT-1:0]  tag_vld_r;

  logic [2:0]              cls;
  logic [MAX_STATIONS-1:0] row;
  logic [3:0]              lim;
  logic                    found;
  logic [SW-1:0]           slot_idx;

  always_comb begin
    cls = class_of_opcode(head_opcode);
    row = '1;
    lim = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (int'(cls) == c) begin
        row = busy_r[c];
        lim = limits[c];
      end
    end
    // Lowest free slot below the configured count; counts past the array clamp naturally.
    found    = 1'b0;
    slot_idx = '0;
    for (int s = MAX_STATIONS - 1; s >= 0; s--) begin
      if (!row[s] && (s < int'(lim))) begin
        found    = 1'b1;
        slot_idx = SW'(s);
      end
    end
  end

  assign status.hit  = found;
  assign status.cls  = cls;
  assign status.slot = 3'(slot_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= '0;
      tag_vld_r <= '0;
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        for (int s = 0; s < MAX_STATIONS; s++) begin
          if (ctl.rel && (int'(ctl.rel_cls) == c) && (int'(ctl.rel_slot) == s)) begin
            busy_r[c][s] <= 1'b0;
          end else if (ctl.alloc && (int'(cls) == c) && (int'(slot_idx) == s)) begin
            busy_r[c][s] <= 1'b1;
          end
        end
      end
      if (ctl.alloc && (cls != CLS_STORE)) begin
        tag_vld_r[ctl.dst] <= 1'b1;
      end
    end
  end

  // Producer tag of a register: class plus one in the upper bits, slot below.
  always_ff @(posedge clk) begin
    if (ctl.alloc && (cls != CLS_STORE)) begin
      tag_mem[ctl.dst] <= {cls + 3'd1, 3'(slot_idx)};
    end
  end

endmodule
